// File: sv/htsr_pkg.sv
`default_nettype none

package htsr_pkg;

  // byte codes
  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // tag prefix table
  localparam int NUM_PAT   = 8;
  localparam int PAT_IDX_W = 3;
  localparam int PAT_POS_W = 3;
  localparam int PAT_LEN_W = 4;

  localparam logic [PAT_IDX_W-1:0] PAT_HEAD_OPEN  = 3'd0;
  localparam logic [PAT_IDX_W-1:0] PAT_HEAD_CLOSE = 3'd1;
  localparam logic [PAT_IDX_W-1:0] PAT_H1_OPEN    = 3'd2;
  localparam logic [PAT_IDX_W-1:0] PAT_H1_CLOSE   = 3'd3;
  localparam logic [PAT_IDX_W-1:0] PAT_P_OPEN     = 3'd4;
  localparam logic [PAT_IDX_W-1:0] PAT_P_CLOSE    = 3'd5;
  localparam logic [PAT_IDX_W-1:0] PAT_LI_OPEN    = 3'd6;
  localparam logic [PAT_IDX_W-1:0] PAT_BR         = 3'd7;

  // prefixes left-justified in seven bytes, padding never compared
  localparam logic [55:0] PAT_TEXT [NUM_PAT] = '{
    "<head  ", "</head>", "<h1>   ", "</h1>  ",
    "<p>    ", "</p>   ", "<li>   ", "<br    "
  };
  localparam logic [PAT_LEN_W-1:0] PAT_LEN [NUM_PAT] = '{
    4'd5, 4'd7, 4'd4, 4'd5, 4'd3, 4'd4, 4'd4, 4'd3
  };

  // queue sizing
  localparam int QUEUE_DEPTH_DEF = 4;

  // kind of output run held in one queue entry
  typedef enum logic [2:0] {
    RUN_CHAR,
    RUN_CRLF,
    RUN_H1_OPEN,
    RUN_H1_CLOSE,
    RUN_ITEM
  } run_t;

  typedef struct packed {
    run_t       kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // byte of a tag prefix at a given position
  function automatic logic [7:0] pat_char(logic [PAT_IDX_W-1:0] idx,
                                          logic [PAT_POS_W-1:0] p);
    logic [55:0] s;
    s = PAT_TEXT[idx];
    return s[55 - 8 * p -: 8];
  endfunction

  // byte of a fixed string at a given position
  function automatic logic [7:0] run_char(run_t k, logic [2:0] idx);
    logic [47:0] s;
    case (k)
      RUN_CRLF:     s = {CH_CR, CH_LF, 32'h0};
      RUN_H1_OPEN:  s = {CH_CR, CH_LF, "=== "};
      RUN_H1_CLOSE: s = {" ===", CH_CR, CH_LF};
      RUN_ITEM:     s = {CH_CR, CH_LF, "  * "};
      default:      s = '0;
    endcase
    return s[47 - 8 * idx -: 8];
  endfunction

  // index of the last byte of a run
  function automatic logic [2:0] run_last(run_t k);
    logic [2:0] n;
    case (k)
      RUN_CHAR: n = 3'd0;
      RUN_CRLF: n = 3'd1;
      default:  n = 3'd5;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// File: sv/htsr_front.sv
`default_nettype none

module htsr_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_req_type,
  input  wire logic [7:0]       in_char_in,
  input  wire htsr_pkg::q_stat_t q_stat,
  output logic                  push,
  output htsr_pkg::cmd_t        push_cmd
);
  import htsr_pkg::*;

  logic                 tag_r, tag_nxt;
  logic                 head_r, head_nxt;
  logic [NUM_PAT-1:0]   mask_r, mask_nxt;
  logic [PAT_POS_W-1:0] pos_r, pos_nxt;

  logic [NUM_PAT-1:0]   hit;
  logic [NUM_PAT-1:0]   done;
  logic [PAT_IDX_W-1:0] done_idx;
  logic                 emit;
  logic                 accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit;

  // compare the byte against every live prefix
  always_comb begin
    hit      = '0;
    done     = '0;
    done_idx = '0;
    for (int i = 0; i < NUM_PAT; i++) begin
      if (mask_r[i] && ({1'b0, pos_r} < PAT_LEN[i]) &&
          (pat_char(i[PAT_IDX_W-1:0], pos_r) == in_char_in)) begin
        hit[i] = 1'b1;
        if ({1'b0, pos_r} + 4'd1 == PAT_LEN[i]) begin
          done[i]  = 1'b1;
          done_idx = i[PAT_IDX_W-1:0];
        end
      end
    end
  end

  // classify the word and work out the next parser state
  always_comb begin
    tag_nxt       = tag_r;
    head_nxt      = head_r;
    mask_nxt      = mask_r;
    pos_nxt       = pos_r;
    emit          = 1'b0;
    push_cmd.kind = RUN_CHAR;
    push_cmd.data = in_char_in;
    if (in_req_type) begin
      tag_nxt       = 1'b0;
      head_nxt      = 1'b0;
      mask_nxt      = '0;
      pos_nxt       = '0;
      emit          = 1'b1;
      push_cmd.kind = RUN_CRLF;
    end else if (in_char_in == CH_LT) begin
      tag_nxt  = 1'b1;
      mask_nxt = '1;
      pos_nxt  = 3'd1;
    end else begin
      if (mask_r != '0) begin
        if (|done) begin
          mask_nxt = '0;
          pos_nxt  = '0;
          unique case (done_idx)
            PAT_HEAD_OPEN:  head_nxt = 1'b1;
            PAT_HEAD_CLOSE: head_nxt = 1'b0;
            PAT_H1_OPEN: begin
              emit          = 1'b1;
              push_cmd.kind = RUN_H1_OPEN;
            end
            PAT_H1_CLOSE: begin
              emit          = 1'b1;
              push_cmd.kind = RUN_H1_CLOSE;
            end
            PAT_LI_OPEN: begin
              emit          = 1'b1;
              push_cmd.kind = RUN_ITEM;
            end
            PAT_P_OPEN, PAT_P_CLOSE, PAT_BR: begin
              emit          = 1'b1;
              push_cmd.kind = RUN_CRLF;
            end
          endcase
        end else begin
          mask_nxt = hit;
          pos_nxt  = (|hit) ? pos_r + 3'd1 : 3'd0;
        end
      end
      // plain text only outside tags and outside the head
      if (in_char_in == CH_GT) begin
        tag_nxt = 1'b0;
      end else if (!tag_r && !head_nxt && !emit) begin
        emit          = 1'b1;
        push_cmd.kind = RUN_CHAR;
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r  <= 1'b0;
      head_r <= 1'b0;
      mask_r <= '0;
      pos_r  <= '0;
    end else if (accept) begin
      tag_r  <= tag_nxt;
      head_r <= head_nxt;
      mask_r <= mask_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/htsr_queue.sv
`default_nettype none

module htsr_queue #(
  parameter int DEPTH = htsr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire htsr_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output htsr_pkg::cmd_t     head_cmd,
  output htsr_pkg::q_stat_t  q_stat
);
  import htsr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign q_stat.full  = (cnt_r == FULL_CNT);
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_cmd     = entry_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// File: sv/htsr_back.sv
`default_nettype none

module htsr_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire htsr_pkg::cmd_t head_cmd,
  input  wire htsr_pkg::q_stat_t q_stat,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last_of_run
);
  import htsr_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       load;
  logic       fire;
  logic [7:0] cur_byte;
  logic       cur_last;

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_last_of_run = last_r;

  // output register takes a new word when empty or being drained
  assign load = !valid_r || out_ready;
  assign fire = load && !q_stat.empty;

  // pick the byte of the run at the current index
  always_comb begin
    cur_byte = (head_cmd.kind == RUN_CHAR) ? head_cmd.data
                                           : run_char(head_cmd.kind, idx_r);
    cur_last = (idx_r == run_last(head_cmd.kind));
    pop      = fire && cur_last;
    idx_nxt  = idx_r;
    if (fire) begin
      idx_nxt = cur_last ? 3'd0 : idx_r + 3'd1;
    end
  end

  // run index and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        valid_r <= fire;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (fire) begin
      byte_r <= cur_byte;
      last_r <= cur_last;
    end
  end

endmodule

`default_nettype wire

// File: sv/html_tag_strip_text_render_top.sv
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_ready   | in_req_type, in_char_in
// out     | output    | out_valid / out_ready | out_byte, out_last_of_run
//
// one input word per cycle while the queue is not full; plain text goes through
// a queue entry and then the output register; a tag string or end of document
// gives a run of up to six words, one a cycle while out_ready holds, paced by the
// single output register of the back end; the command queue between parser and
// emitter absorbs runs; in_ready drops only while it is full
// synchronous active-low reset clears parser state, queue and output valid
`default_nettype none

module html_tag_strip_text_render_top #(
  parameter int QUEUE_DEPTH = htsr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_req_type,
  input  wire logic [7:0] in_char_in,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last_of_run
);
  import htsr_pkg::*;

  q_stat_t q_stat;
  cmd_t    push_cmd;
  cmd_t    head_cmd;
  logic    push;
  logic    pop;

  // parser and classifier
  htsr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_char_in  (in_char_in),
    .q_stat      (q_stat),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  // command queue
  htsr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  // string emitter
  htsr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_cmd        (head_cmd),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

// File: sv/htsr_check.sv
`default_nettype none

module htsr_check (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last_of_run
);
  import htsr_pkg::*;

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
                                $stable(out_last_of_run))
    else $error("output word changed while stalled");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // reset empties the queue so input is taken at once
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

  // angle brackets never reach the text
  a_no_bracket: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte != CH_LT) && (out_byte != CH_GT))
    else $error("tag bracket in rendered text");

endmodule

bind html_tag_strip_text_render_top htsr_check u_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte        (out_byte),
  .out_last_of_run (out_last_of_run)
);

`default_nettype wire
